FILE: src/mspv2_pkg.sv
// Package with the item types, codes and CRC helper of the MSP v2 frame parser.
`timescale 1ns / 1ps

package mspv2_pkg;

  // Frame tracking phases.
  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_WANT_X  = 4'd1,
    PH_WANT_GT = 4'd2,
    PH_FLAG    = 4'd3,
    PH_ID_LO   = 4'd4,
    PH_ID_HI   = 4'd5,
    PH_SIZE_LO = 4'd6,
    PH_SIZE_HI = 4'd7,
    PH_PAYLOAD = 4'd8,
    PH_CKSUM   = 4'd9
  } phase_e;

  // Event codes reported with every result item.
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_DATA = 2'd1;
  localparam logic [1:0] EV_GOOD = 2'd2;
  localparam logic [1:0] EV_BAD  = 2'd3;

  // Header characters and CRC constants.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CRC_POLY  = 8'hD5;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'hFFFF;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  data_byte;
    logic [15:0] payload_index;
    logic [15:0] message_id;
    logic [15:0] payload_length;
  } out_item_t;

  // One byte of CRC-8/DVB-S2, MSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

FILE: src/mspv2_stream_if.sv
// Valid/ready stream interface that carries one item of a given type.
`timescale 1ns / 1ps

interface mspv2_stream_if #(
  parameter type T = logic [7:0]
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/msp_v2_frame_parser.sv
// MSP v2 frame parser with running CRC-8/DVB-S2 check, one received byte per item.
`timescale 1ns / 1ps
// Latency: the result for a byte is valid in the cycle after the byte is accepted.
// Throughput: one byte per cycle while res_o is ready; the single result register refills
// as it drains. The per-byte CRC-8 and phase update between input and result sets the rate.
// Reset: rst_ni clears the phase, CRC, id, size and byte count and sets max_payload to 65535.

module msp_v2_frame_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [15:0]            cfg_data_i,
  mspv2_stream_if.sink           rx_i,
  mspv2_stream_if.source         res_o
);

  mspv2_pkg::phase_e phase_q, phase_d;
  logic [7:0]        crc_q, crc_d;
  logic [15:0]       id_q, id_d;
  logic [15:0]       size_q, size_d;
  logic [15:0]       seen_q, seen_d;
  logic [15:0]       max_payload_q;
  logic              out_valid_q;
  mspv2_pkg::out_item_t out_q, out_d;

  logic       in_fire;
  logic [7:0] c;
  logic [7:0] crc_upd;
  logic [15:0] seen_inc;

  // Accept a new byte whenever the result register is empty or being drained.
  assign rx_i.ready  = !out_valid_q || res_o.ready;
  assign in_fire     = rx_i.valid && rx_i.ready;
  assign c           = rx_i.data.rx_byte;
  assign crc_upd     = mspv2_pkg::crc8_update(crc_q, c);
  assign seen_inc    = seen_q + 16'd1;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      mspv2_pkg::PH_WANT_X: begin
        phase_d = (c == mspv2_pkg::CH_X) ? mspv2_pkg::PH_WANT_GT : mspv2_pkg::PH_HUNT;
      end
      mspv2_pkg::PH_WANT_GT: begin
        phase_d = (c == mspv2_pkg::CH_GT) ? mspv2_pkg::PH_FLAG : mspv2_pkg::PH_HUNT;
      end
      mspv2_pkg::PH_FLAG:    phase_d = mspv2_pkg::PH_ID_LO;
      mspv2_pkg::PH_ID_LO:   phase_d = mspv2_pkg::PH_ID_HI;
      mspv2_pkg::PH_ID_HI:   phase_d = mspv2_pkg::PH_SIZE_LO;
      mspv2_pkg::PH_SIZE_LO: phase_d = mspv2_pkg::PH_SIZE_HI;
      mspv2_pkg::PH_SIZE_HI: begin
        phase_d = ({c, size_q[7:0]} != 16'd0) ? mspv2_pkg::PH_PAYLOAD : mspv2_pkg::PH_CKSUM;
      end
      mspv2_pkg::PH_PAYLOAD: begin
        phase_d = (seen_inc >= size_q) ? mspv2_pkg::PH_CKSUM : mspv2_pkg::PH_PAYLOAD;
      end
      mspv2_pkg::PH_CKSUM:   phase_d = mspv2_pkg::PH_HUNT;
      default: begin
        phase_d = (c == mspv2_pkg::CH_DOLLAR) ? mspv2_pkg::PH_WANT_X : mspv2_pkg::PH_HUNT;
      end
    endcase
  end

  // Frame state and result item.
  always_comb begin
    crc_d  = crc_q;
    id_d   = id_q;
    size_d = size_q;
    seen_d = seen_q;
    out_d.event_res     = mspv2_pkg::EV_NONE;
    out_d.data_byte     = 8'd0;
    out_d.payload_index = 16'd0;
    case (phase_q)
      mspv2_pkg::PH_FLAG: begin
        crc_d  = mspv2_pkg::crc8_update(8'd0, c);
        id_d   = 16'd0;
        size_d = 16'd0;
        seen_d = 16'd0;
      end
      mspv2_pkg::PH_ID_LO: begin
        id_d  = {8'd0, c};
        crc_d = crc_upd;
      end
      mspv2_pkg::PH_ID_HI: begin
        id_d  = {c, id_q[7:0]};
        crc_d = crc_upd;
      end
      mspv2_pkg::PH_SIZE_LO: begin
        size_d = {8'd0, c};
        crc_d  = crc_upd;
      end
      mspv2_pkg::PH_SIZE_HI: begin
        size_d = {c, size_q[7:0]};
        crc_d  = crc_upd;
        seen_d = 16'd0;
      end
      mspv2_pkg::PH_PAYLOAD: begin
        if (seen_q < max_payload_q) begin
          out_d.event_res     = mspv2_pkg::EV_DATA;
          out_d.data_byte     = c;
          out_d.payload_index = seen_q;
        end
        crc_d  = crc_upd;
        seen_d = seen_inc;
      end
      mspv2_pkg::PH_CKSUM: begin
        out_d.event_res = (c == crc_q) ? mspv2_pkg::EV_GOOD : mspv2_pkg::EV_BAD;
      end
      default: begin
        crc_d = crc_q;
      end
    endcase
    out_d.message_id     = id_d;
    out_d.payload_length = size_d;
  end

  // Control and frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= mspv2_pkg::PH_HUNT;
      crc_q         <= 8'd0;
      id_q          <= 16'd0;
      size_q        <= 16'd0;
      seen_q        <= 16'd0;
      max_payload_q <= mspv2_pkg::MAX_PAYLOAD_RST;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_payload_q <= cfg_data_i;
      end
      if (in_fire) begin
        phase_q     <= phase_d;
        crc_q       <= crc_d;
        id_q        <= id_d;
        size_q      <= size_d;
        seen_q      <= seen_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTH
  // The checksum byte always ends the frame with a status and restarts hunting.
  a_cksum_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (phase_q == mspv2_pkg::PH_CKSUM) |=> (phase_q == mspv2_pkg::PH_HUNT) &&
      out_valid_q &&
      ((out_q.event_res == mspv2_pkg::EV_GOOD) || (out_q.event_res == mspv2_pkg::EV_BAD)))
    else $error("checksum byte did not end the frame");

  // While payload is expected, fewer bytes than declared have been consumed.
  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == mspv2_pkg::PH_PAYLOAD) |-> (seen_q < size_q))
    else $error("payload count reached declared size without leaving payload phase");

  // Every accepted byte leaves a result in the register.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted byte produced no result");

  // Frame state moves only when a byte is accepted.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(phase_q) && $stable(crc_q) && $stable(seen_q))
    else $error("frame state changed without an accepted byte");
`endif

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the MSP v2 frame parser with CRC-8 frame checking.
`timescale 1ns / 1ps

module testbench;

  // Tracks the parser state per accepted byte and holds the result items still owed.
  class frame_scoreboard;
    mspv2_pkg::phase_e    trk_phase;
    logic [7:0]           crc_acc;
    logic [15:0]          cur_id;
    logic [15:0]          cur_size;
    logic [15:0]          seen_cnt;
    logic [15:0]          deliver_limit;
    mspv2_pkg::out_item_t owed_q[$];
    int                   mismatches;

    function void clear();
      trk_phase     = mspv2_pkg::PH_HUNT;
      crc_acc       = 8'h00;
      cur_id        = 16'h0000;
      cur_size      = 16'h0000;
      seen_cnt      = 16'h0000;
      deliver_limit = 16'hFFFF;
      mismatches    = 0;
      owed_q.delete();
    endfunction

    function void set_limit(logic [15:0] v);
      deliver_limit = v;
    endfunction

    function int pending_count();
      return owed_q.size();
    endfunction

    // CRC-8/DVB-S2 over one byte, shifted out MSB first.
    static function logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
      logic [7:0] r;
      r = crc ^ b;
      for (int k = 0; k < 8; k++) begin
        if (r[7]) begin
          r = (r << 1) ^ mspv2_pkg::CRC_POLY;
        end else begin
          r = r << 1;
        end
      end
      return r;
    endfunction

    // Advances the frame tracker by one accepted byte and queues the result it causes.
    function void note_byte(logic [7:0] b);
      mspv2_pkg::out_item_t e;
      e = '0;
      case (trk_phase)
        mspv2_pkg::PH_WANT_X: begin
          trk_phase = (b == mspv2_pkg::CH_X) ? mspv2_pkg::PH_WANT_GT : mspv2_pkg::PH_HUNT;
        end
        mspv2_pkg::PH_WANT_GT: begin
          trk_phase = (b == mspv2_pkg::CH_GT) ? mspv2_pkg::PH_FLAG : mspv2_pkg::PH_HUNT;
        end
        mspv2_pkg::PH_FLAG: begin
          crc_acc   = crc8_step(8'h00, b);
          cur_id    = 16'h0000;
          cur_size  = 16'h0000;
          seen_cnt  = 16'h0000;
          trk_phase = mspv2_pkg::PH_ID_LO;
        end
        mspv2_pkg::PH_ID_LO: begin
          cur_id    = {8'h00, b};
          crc_acc   = crc8_step(crc_acc, b);
          trk_phase = mspv2_pkg::PH_ID_HI;
        end
        mspv2_pkg::PH_ID_HI: begin
          cur_id    = {b, cur_id[7:0]};
          crc_acc   = crc8_step(crc_acc, b);
          trk_phase = mspv2_pkg::PH_SIZE_LO;
        end
        mspv2_pkg::PH_SIZE_LO: begin
          cur_size  = {8'h00, b};
          crc_acc   = crc8_step(crc_acc, b);
          trk_phase = mspv2_pkg::PH_SIZE_HI;
        end
        mspv2_pkg::PH_SIZE_HI: begin
          cur_size  = {b, cur_size[7:0]};
          crc_acc   = crc8_step(crc_acc, b);
          seen_cnt  = 16'h0000;
          trk_phase = (cur_size > 16'h0000) ? mspv2_pkg::PH_PAYLOAD : mspv2_pkg::PH_CKSUM;
        end
        mspv2_pkg::PH_PAYLOAD: begin
          if (seen_cnt < deliver_limit) begin
            e.event_res     = mspv2_pkg::EV_DATA;
            e.data_byte     = b;
            e.payload_index = seen_cnt;
          end
          crc_acc  = crc8_step(crc_acc, b);
          seen_cnt = seen_cnt + 16'd1;
          if (seen_cnt >= cur_size) begin
            trk_phase = mspv2_pkg::PH_CKSUM;
          end
        end
        mspv2_pkg::PH_CKSUM: begin
          e.event_res = (b == crc_acc) ? mspv2_pkg::EV_GOOD : mspv2_pkg::EV_BAD;
          trk_phase   = mspv2_pkg::PH_HUNT;
        end
        default: begin
          trk_phase = (b == mspv2_pkg::CH_DOLLAR) ? mspv2_pkg::PH_WANT_X : mspv2_pkg::PH_HUNT;
        end
      endcase
      e.message_id     = cur_id;
      e.payload_length = cur_size;
      owed_q.push_back(e);
    endfunction

    // Compares one result item with the oldest one owed.
    function void check_result(mspv2_pkg::out_item_t got);
      mspv2_pkg::out_item_t e;
      bit                   bad;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] result item with none owed: %p", $time, got);
        end
        return;
      end
      e   = owed_q.pop_front();
      bad = 1'b0;
      if (got.event_res !== e.event_res) bad = 1'b1;
      if (got.data_byte !== e.data_byte) bad = 1'b1;
      if (got.payload_index !== e.payload_index) bad = 1'b1;
      if (got.message_id !== e.message_id) bad = 1'b1;
      if (got.payload_length !== e.payload_length) bad = 1'b1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] result mismatch: expected ev=%0d byte=%h idx=%0d id=%h len=%0d",
                   $time, e.event_res, e.data_byte, e.payload_index, e.message_id,
                   e.payload_length);
          $display("                      actual   ev=%0d byte=%h idx=%0d id=%h len=%0d",
                   got.event_res, got.data_byte, got.payload_index, got.message_id,
                   got.payload_length);
        end
      end
    endfunction
  endclass

  localparam int LONG_HOLD = 50;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_data_i;

  mspv2_stream_if #(.T(mspv2_pkg::in_item_t))  rx_if ();
  mspv2_stream_if #(.T(mspv2_pkg::out_item_t)) res_if ();

  frame_scoreboard sb;

  bit     rx_offering = 1'b0;
  longint lowered_at = -1;
  bit     hold_req = 1'b0;
  int     tx_gap_pct = 20;
  int     res_stall_pct = 20;
  int     frame_items = 0;

  msp_v2_frame_parser i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) begin
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      return $urandom_range(10, 30);
    end
    return $urandom_range(1, 3);
  endfunction

  // Withdraws the offered item, if any.
  task automatic idle_rx();
    if (rx_offering) begin
      rx_if.valid <= 1'b0;
      rx_offering = 1'b0;
      lowered_at  = $time;
    end
  endtask

  // Offers one byte and waits until the parser takes it.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(tx_gap_pct);
    if (gap > 0) begin
      idle_rx();
      repeat (gap) @(posedge clk_i);
    end else if (!rx_offering && lowered_at == $time) begin
      @(posedge clk_i);
    end
    rx_if.valid        <= 1'b1;
    rx_if.data.rx_byte <= b;
    rx_offering = 1'b1;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    sb.note_byte(b);
  endtask

  // Stops offering until every owed result item has arrived.
  task automatic pause_until_drained();
    idle_rx();
    while (sb.pending_count() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] v);
    pause_until_drained();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_limit(v);
  endtask

  // Sends a whole frame with random payload and a good or corrupted checksum.
  task automatic send_frame(input logic [7:0] flag, input logic [15:0] id,
                            input logic [15:0] size, input bit good);
    logic [7:0] crc;
    logic [7:0] pb;
    crc = frame_scoreboard::crc8_step(8'h00, flag);
    send_byte(mspv2_pkg::CH_DOLLAR);
    send_byte(mspv2_pkg::CH_X);
    send_byte(mspv2_pkg::CH_GT);
    send_byte(flag);
    crc = frame_scoreboard::crc8_step(crc, id[7:0]);
    send_byte(id[7:0]);
    crc = frame_scoreboard::crc8_step(crc, id[15:8]);
    send_byte(id[15:8]);
    crc = frame_scoreboard::crc8_step(crc, size[7:0]);
    send_byte(size[7:0]);
    crc = frame_scoreboard::crc8_step(crc, size[15:8]);
    send_byte(size[15:8]);
    for (int k = 0; k < int'(size); k++) begin
      pb  = 8'($urandom);
      crc = frame_scoreboard::crc8_step(crc, pb);
      send_byte(pb);
    end
    send_byte(good ? crc : crc ^ 8'($urandom_range(1, 255)));
    frame_items += int'(size) + 9;
  endtask

  // Header bytes and stray bytes that mostly keep the parser hunting.
  task automatic send_noise();
    int n;
    int r;
    n = $urandom_range(1, 4);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 5);
      case (r)
        0, 1: send_byte(mspv2_pkg::CH_DOLLAR);
        2: send_byte(mspv2_pkg::CH_X);
        3: send_byte(mspv2_pkg::CH_GT);
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  // A header broken after the dollar or after the 'X'.
  task automatic send_broken_header();
    logic [7:0] b;
    send_byte(mspv2_pkg::CH_DOLLAR);
    if ($urandom_range(0, 1) == 0) begin
      b = 8'($urandom);
      if (b == mspv2_pkg::CH_X) b = mspv2_pkg::CH_DOLLAR;
      send_byte(b);
    end else begin
      send_byte(mspv2_pkg::CH_X);
      b = 8'($urandom);
      if (b == mspv2_pkg::CH_GT) b = mspv2_pkg::CH_X;
      send_byte(b);
    end
  endtask

  function automatic logic [15:0] pick_size();
    if ($urandom_range(0, 9) == 0) begin
      return 16'($urandom_range(13, 40));
    end
    return 16'($urandom_range(0, 12));
  endfunction

  // Picks the idling of both sides for the next stretch of stimulus.
  task automatic pick_idling();
    case ($urandom_range(0, 3))
      0: begin tx_gap_pct = 0;  res_stall_pct = 0;  end
      1: begin tx_gap_pct = 30; res_stall_pct = 0;  end
      2: begin tx_gap_pct = 0;  res_stall_pct = 30; end
      default: begin tx_gap_pct = 25; res_stall_pct = 25; end
    endcase
  endtask

  task automatic random_step();
    int r;
    pick_idling();
    r = $urandom_range(0, 99);
    if (r < 72) begin
      send_frame(8'($urandom), 16'($urandom), pick_size(), $urandom_range(0, 6) != 0);
    end else if (r < 84) begin
      send_broken_header();
    end else if (r < 95) begin
      send_noise();
    end else begin
      pause_until_drained();
    end
  endtask

  // Result side: checks every accepted item and stalls at random.
  initial begin : result_sink
    int stall;
    stall = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        sb.check_result(res_if.data);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = LONG_HOLD;
      end else if (stall == 0) begin
        stall = pick_gap(res_stall_pct);
      end
      if (stall > 0) begin
        stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Main stimulus: reset, directed frames, then phases at different delivery limits.
  initial begin : stimulus
    logic [15:0] limits [8];
    int          goal;
    sb = new;
    sb.clear();
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_data_i         <= 16'h0000;
    rx_if.valid        <= 1'b0;
    rx_if.data.rx_byte <= 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A dollar while waiting for 'X' drops back to hunting, not to a new header.
    send_byte(mspv2_pkg::CH_DOLLAR);
    send_byte(mspv2_pkg::CH_DOLLAR);
    send_byte(mspv2_pkg::CH_X);
    send_byte(mspv2_pkg::CH_GT);
    // A wrong byte while waiting for '>'.
    send_byte(mspv2_pkg::CH_DOLLAR);
    send_byte(mspv2_pkg::CH_X);
    send_byte(8'h00);
    // Empty payload with all-ones fields, then a one-byte payload with a bad checksum.
    send_frame(8'hFF, 16'hFFFF, 16'h0000, 1'b1);
    send_frame(8'h00, 16'h0000, 16'h0001, 1'b0);

    limits[0] = 16'hFFFF;
    limits[1] = 16'h0000;
    limits[2] = 16'd3;
    limits[3] = 16'd1;
    limits[4] = 16'($urandom_range(2, 12));
    limits[5] = 16'd256;
    limits[6] = 16'hFFFF;
    limits[7] = 16'($urandom_range(0, 20));

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        write_limit(limits[ph]);
      end
      goal = frame_items + 165;
      // The result side holds off while bytes keep coming, so the parser backs up.
      tx_gap_pct    = 0;
      res_stall_pct = 0;
      hold_req      = 1'b1;
      send_frame(8'($urandom), 16'($urandom), 16'($urandom_range(8, 16)), 1'b1);
      if (ph == 5) begin
        send_frame(8'($urandom), 16'($urandom), 16'd300, 1'b1);
      end
      while (frame_items < goal) random_step();
    end

    pause_until_drained();
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("msp_v2_frame_parser verification clean");
    end else begin
      $display("msp_v2_frame_parser verification failed");
    end
    $finish;
  end

  // Ends a run that hangs.
  initial begin : watchdog
    #10_000_000;
    $display("msp_v2_frame_parser verification failed");
    $finish;
  end

endmodule

FILE: files.f
src/mspv2_pkg.sv
src/mspv2_stream_if.sv
src/msp_v2_frame_parser.sv
verif/testbench.sv
